// ===== design/vpr_pkg.sv =====
// Shared types, constants and helper functions for the vector polar/rectangular unit.
// No dependencies; vpr_rotate, vpr_vector and the top level import this package.
`default_nettype none

package vpr_pkg;

    // Stage count limits
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int MAX_STAGES        = 32;

    // Datapath widths: x/y carry Q16.16 plus 28 extra fraction bits, z is in 2^-30 rad
    localparam int XY_W = 64;
    localparam int Z_W  = 40;
    localparam int P_W  = 68;

    // Command codes
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_SUB   = 2'd1;
    localparam logic [1:0] CMD_PASS  = 2'd2;
    localparam logic [1:0] CMD_POLAR = 2'd3;

    typedef logic signed [XY_W-1:0] xy_t;
    typedef logic signed [Z_W-1:0]  z_t;

    // Fixed-point constants
    localparam z_t                 HALF_PI_Q30 = 40'sd1686629713;
    localparam z_t                 ANGLE_LIMIT = 40'sd25736;
    localparam z_t                 RND_Z17     = 40'sd65536;
    localparam logic signed [31:0] GAIN_Q30    = 32'sd652032874;
    localparam logic [21:0]        GAIN_Q22    = 22'd2547003;
    localparam xy_t                RND_Q28     = 64'sd134217728;
    localparam xy_t                S32_MAX     = 64'sd2147483647;
    localparam xy_t                S32_MIN     = -64'sd2147483648;

    typedef struct packed {
        logic signed [31:0] vertical;
        logic signed [31:0] horizontal;
        logic               overflow;
    } comp_t;

    typedef struct packed {
        logic  polar;
        xy_t   x;
        z_t    z;
        comp_t comp;
    } rot_req_t;

    typedef struct packed {
        logic signed [31:0] vertical;
        logic signed [31:0] horizontal;
        logic [31:0]        length;
        logic signed [15:0] angle;
        logic               overflow;
    } res_t;

    typedef struct packed {
        logic               ovf;
        logic signed [31:0] val;
    } sat_t;

    // Clamp a wide signed value to the signed 32-bit range
    function automatic sat_t sat32(input xy_t v);
        sat_t r;
        r.ovf = 1'b0;
        r.val = v[31:0];
        if (v > S32_MAX)
        begin
            r.ovf = 1'b1;
            r.val = 32'sh7FFF_FFFF;
        end
        else if (v < S32_MIN)
        begin
            r.ovf = 1'b1;
            r.val = 32'sh8000_0000;
        end
        return r;
    endfunction

    // arctan(2^-i) in units of 2^-30 rad, truncated
    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:  r = 32'h3243F6A8;
            5'd1:  r = 32'h1DAC6705;
            5'd2:  r = 32'h0FADBAFC;
            5'd3:  r = 32'h07F56EA6;
            5'd4:  r = 32'h03FEAB76;
            5'd5:  r = 32'h01FFD55B;
            5'd6:  r = 32'h00FFFAAA;
            5'd7:  r = 32'h007FFF55;
            5'd8:  r = 32'h003FFFEA;
            5'd9:  r = 32'h001FFFFD;
            5'd10: r = 32'h000FFFFF;
            5'd11: r = 32'h0007FFFF;
            5'd12: r = 32'h0003FFFF;
            5'd13: r = 32'h0001FFFF;
            5'd14: r = 32'h0000FFFF;
            5'd15: r = 32'h00007FFF;
            5'd16: r = 32'h00003FFF;
            5'd17: r = 32'h00001FFF;
            5'd18: r = 32'h00000FFF;
            5'd19: r = 32'h000007FF;
            5'd20: r = 32'h000003FF;
            5'd21: r = 32'h000001FF;
            5'd22: r = 32'h000000FF;
            5'd23: r = 32'h0000007F;
            5'd24: r = 32'h0000003F;
            5'd25: r = 32'h0000001F;
            5'd26: r = 32'h0000000F;
            5'd27: r = 32'h00000008;
            5'd28: r = 32'h00000004;
            5'd29: r = 32'h00000002;
            5'd30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/vpr_in_if.sv =====
// Request channel carrying one command and its operands.
// Standalone interface; no package dependency.
`default_nettype none

interface vpr_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic signed [31:0] a_vertical;
    logic signed [31:0] a_horizontal;
    logic signed [31:0] b_vertical;
    logic signed [31:0] b_horizontal;
    logic signed [31:0] polar_length;
    logic signed [15:0] polar_angle;

    modport source (
        output valid, command, a_vertical, a_horizontal, b_vertical, b_horizontal,
               polar_length, polar_angle,
        input  ready
    );

    modport sink (
        input  valid, command, a_vertical, a_horizontal, b_vertical, b_horizontal,
               polar_length, polar_angle,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/vpr_out_if.sv =====
// Result channel carrying components, magnitude, direction and overflow flag.
// Standalone interface; no package dependency.
`default_nettype none

interface vpr_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_vertical;
    logic signed [31:0] out_horizontal;
    logic [31:0]        out_length;
    logic signed [15:0] out_angle;
    logic               overflow;

    modport source (
        output valid, out_vertical, out_horizontal, out_length, out_angle, overflow,
        input  ready
    );

    modport sink (
        input  valid, out_vertical, out_horizontal, out_length, out_angle, overflow,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/vpr_rotate.sv =====
// Rotation-mode CORDIC pipeline: quadrant reduction, one register stage per
// iteration, then rounding and saturation to Q16.16. Depends on vpr_pkg.
`default_nettype none

module vpr_rotate #(
    parameter int STAGES = vpr_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire logic             req_valid,
    input  wire vpr_pkg::rot_req_t req,
    output logic                  rsp_valid,
    output vpr_pkg::comp_t        rsp
);
    import vpr_pkg::*;

    localparam int N = (STAGES > MAX_STAGES) ? MAX_STAGES : ((STAGES < 1) ? 1 : STAGES);

    xy_t   x_reg     [0:N];
    xy_t   y_reg     [0:N];
    z_t    z_reg     [0:N];
    logic  vld_reg   [0:N];
    logic  polar_reg [0:N];
    comp_t pass_reg  [0:N];

    xy_t   rx_next;
    xy_t   ry_next;
    z_t    rz_next;
    xy_t   swap;
    sat_t  sat_v;
    sat_t  sat_h;
    comp_t rsp_next;
    logic  rsp_vld_reg;
    comp_t rsp_reg;

    // Fold the angle into [-pi/2, pi/2] with up to two quarter turns
    always_comb
    begin
        rx_next = req.x;
        ry_next = '0;
        rz_next = req.z;
        swap    = '0;
        for (int k = 0; k < 2; k++)
        begin
            if (rz_next > HALF_PI_Q30)
            begin
                swap    = rx_next;
                rx_next = -ry_next;
                ry_next = swap;
                rz_next = rz_next - HALF_PI_Q30;
            end
            else if (rz_next < -HALF_PI_Q30)
            begin
                swap    = rx_next;
                rx_next = ry_next;
                ry_next = -swap;
                rz_next = rz_next + HALF_PI_Q30;
            end
        end
    end

    // Reduction stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg[0] <= req_valid;
        end
    end

    // Reduction stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg[0]     <= rx_next;
            y_reg[0]     <= ry_next;
            z_reg[0]     <= rz_next;
            polar_reg[0] <= req.polar;
            pass_reg[0]  <= req.comp;
        end
    end

    // One micro-rotation per stage
    for (genvar i = 0; i < N; i++)
    begin : g_iter
        xy_t x_next;
        xy_t y_next;
        z_t  z_next;
        z_t  step;

        always_comb
        begin
            step = z_t'(atan_q30(5'(i)));
            if (z_reg[i] >= 0)
            begin
                x_next = x_reg[i] - (y_reg[i] >>> i);
                y_next = y_reg[i] + (x_reg[i] >>> i);
                z_next = z_reg[i] - step;
            end
            else
            begin
                x_next = x_reg[i] + (y_reg[i] >>> i);
                y_next = y_reg[i] - (x_reg[i] >>> i);
                z_next = z_reg[i] + step;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (advance)
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                x_reg[i+1]     <= x_next;
                y_reg[i+1]     <= y_next;
                z_reg[i+1]     <= z_next;
                polar_reg[i+1] <= polar_reg[i];
                pass_reg[i+1]  <= pass_reg[i];
            end
        end
    end

    // Round to Q16.16, saturate, or pick the pass-through components
    always_comb
    begin
        sat_v = sat32((y_reg[N] + RND_Q28) >>> 28);
        sat_h = sat32((x_reg[N] + RND_Q28) >>> 28);
        if (polar_reg[N])
        begin
            rsp_next.vertical   = sat_v.val;
            rsp_next.horizontal = sat_h.val;
            rsp_next.overflow   = sat_v.ovf | sat_h.ovf;
        end
        else
        begin
            rsp_next = pass_reg[N];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_vld_reg <= vld_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ===== design/vpr_vector.sv =====
// Vectoring-mode CORDIC pipeline: half-plane fold, one stage per iteration,
// gain-corrected magnitude over two stages and rounded angle. Depends on vpr_pkg.
`default_nettype none

module vpr_vector #(
    parameter int STAGES = vpr_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          advance,
    input  wire logic          req_valid,
    input  wire vpr_pkg::comp_t req,
    output logic               rsp_valid,
    output vpr_pkg::res_t      rsp
);
    import vpr_pkg::*;

    localparam int N = (STAGES > MAX_STAGES) ? MAX_STAGES : ((STAGES < 1) ? 1 : STAGES);

    xy_t   x_reg    [0:N];
    xy_t   y_reg    [0:N];
    z_t    z_reg    [0:N];
    logic  vld_reg  [0:N];
    logic  zero_reg [0:N];
    comp_t comp_reg [0:N];

    xy_t   xi;
    xy_t   yi;
    xy_t   px_next;
    xy_t   py_next;
    z_t    pz_next;

    // Magnitude and angle stages
    xy_t                      xs;
    z_t                       az;
    logic [45:0]              plo_next;
    logic signed [42:0]       phi_next;
    logic signed [15:0]       ang_next;
    logic [45:0]              plo_reg;
    logic signed [42:0]       phi_reg;
    logic signed [15:0]       ang1_reg;
    logic                     zero1_reg;
    comp_t                    comp1_reg;
    logic                     p1_vld_reg;
    logic signed [P_W-1:0]    psum;
    logic signed [P_W-1:0]    lq;
    logic [31:0]              len_next;
    res_t                     rsp_reg;
    logic                     rsp_vld_reg;

    // Scale to the datapath and fold the left half-plane onto the right
    always_comb
    begin
        xi      = xy_t'(req.horizontal) <<< 28;
        yi      = xy_t'(req.vertical) <<< 28;
        px_next = xi;
        py_next = yi;
        pz_next = '0;
        if (xi < 0)
        begin
            if (yi >= 0)
            begin
                px_next = yi;
                py_next = -xi;
                pz_next = HALF_PI_Q30;
            end
            else
            begin
                px_next = -yi;
                py_next = xi;
                pz_next = -HALF_PI_Q30;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg[0] <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg[0]    <= px_next;
            y_reg[0]    <= py_next;
            z_reg[0]    <= pz_next;
            zero_reg[0] <= (req.vertical == '0) && (req.horizontal == '0);
            comp_reg[0] <= req;
        end
    end

    // Drive y toward zero, one step per stage
    for (genvar i = 0; i < N; i++)
    begin : g_iter
        xy_t x_next;
        xy_t y_next;
        z_t  z_next;
        z_t  step;

        always_comb
        begin
            step = z_t'(atan_q30(5'(i)));
            if (y_reg[i] < 0)
            begin
                x_next = x_reg[i] - (y_reg[i] >>> i);
                y_next = y_reg[i] + (x_reg[i] >>> i);
                z_next = z_reg[i] - step;
            end
            else
            begin
                x_next = x_reg[i] + (y_reg[i] >>> i);
                y_next = y_reg[i] - (x_reg[i] >>> i);
                z_next = z_reg[i] + step;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (advance)
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                x_reg[i+1]    <= x_next;
                y_reg[i+1]    <= y_next;
                z_reg[i+1]    <= z_next;
                zero_reg[i+1] <= zero_reg[i];
                comp_reg[i+1] <= comp_reg[i];
            end
        end
    end

    // Gain partial products on the upper and lower halves; round and clamp the angle
    always_comb
    begin
        xs       = x_reg[N] >>> 20;
        plo_next = 46'(xs[23:0]) * 46'(GAIN_Q22);
        phi_next = 43'($signed(xs[43:24])) * 43'($signed({1'b0, GAIN_Q22}));
        az       = (z_reg[N] + RND_Z17) >>> 17;
        if (zero_reg[N])
        begin
            ang_next = '0;
        end
        else if (az > ANGLE_LIMIT)
        begin
            ang_next = ANGLE_LIMIT[15:0];
        end
        else if (az < -ANGLE_LIMIT)
        begin
            ang_next = 16'(-ANGLE_LIMIT);
        end
        else
        begin
            ang_next = az[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            p1_vld_reg <= vld_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            plo_reg   <= plo_next;
            phi_reg   <= phi_next;
            ang1_reg  <= ang_next;
            zero1_reg <= zero_reg[N];
            comp1_reg <= comp_reg[N];
        end
    end

    // Combine partial products, round, clamp to unsigned 32 bits
    always_comb
    begin
        psum = (P_W'(phi_reg) <<< 24) + P_W'(plo_reg) + P_W'(1 << 29);
        lq   = psum >>> 30;
        if (zero1_reg || lq[P_W-1])
        begin
            len_next = '0;
        end
        else if (lq[P_W-2:32] != '0)
        begin
            len_next = '1;
        end
        else
        begin
            len_next = lq[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_vld_reg <= p1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg.vertical   <= comp1_reg.vertical;
            rsp_reg.horizontal <= comp1_reg.horizontal;
            rsp_reg.overflow   <= comp1_reg.overflow;
            rsp_reg.length     <= len_next;
            rsp_reg.angle      <= ang1_reg;
        end
    end

    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ===== design/vector_polar_rect_unit.sv =====
// Top level of the vector polar/rectangular unit; uses vpr_pkg, vpr_in_if,
// vpr_out_if, vpr_rotate and vpr_vector.
`default_nettype none

// Fully pipelined two-dimensional vector unit. Each request (add, subtract,
// pass components, or convert from polar) yields one result with saturated
// Q16.16 components, the unsigned Q16.16 magnitude and the atan2 direction in
// Q2.13 radians. One request is accepted every clock cycle while ready is
// high. A request passes in order through the entry stage, the rotation
// CORDIC (reduction, CORDIC_STAGES iterations, rounding), the vectoring
// CORDIC (fold, CORDIC_STAGES iterations, two magnitude stages) and the
// output register. A two-entry output buffer lets one more request in while
// a result waits; after that, ready drops until the result channel drains.
// Results keep request order. CORDIC_STAGES is clamped to the range 1 to 32.
module vector_polar_rect_unit #(
    parameter int CORDIC_STAGES = vpr_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    vpr_in_if.sink      operand,
    vpr_out_if.source   result
);
    import vpr_pkg::*;

    logic               advance;
    logic signed [32:0] sum_v;
    logic signed [32:0] sum_h;
    sat_t               sat_v;
    sat_t               sat_h;
    xy_t                prod;
    rot_req_t           ent_next;
    rot_req_t           ent_reg;
    logic               ent_vld_reg;

    logic               rot_valid;
    comp_t              rot_comp;
    logic               vec_valid;
    res_t               vec_res;

    logic               up_fire;
    logic               out_load;
    logic               out_vld_reg;
    logic               out_vld_next;
    res_t               out_reg;
    res_t               out_next;
    logic               skid_vld_reg;
    logic               skid_vld_next;
    res_t               skid_reg;

    // Whole pipeline moves while the output buffer has room
    assign advance       = !skid_vld_reg;
    assign operand.ready = advance;

    // Decode the command; form components or prescale the polar length
    always_comb
    begin
        unique case (operand.command)
            CMD_ADD:
            begin
                sum_v = {operand.a_vertical[31], operand.a_vertical}
                      + {operand.b_vertical[31], operand.b_vertical};
                sum_h = {operand.a_horizontal[31], operand.a_horizontal}
                      + {operand.b_horizontal[31], operand.b_horizontal};
            end
            CMD_SUB:
            begin
                sum_v = {operand.a_vertical[31], operand.a_vertical}
                      - {operand.b_vertical[31], operand.b_vertical};
                sum_h = {operand.a_horizontal[31], operand.a_horizontal}
                      - {operand.b_horizontal[31], operand.b_horizontal};
            end
            default:
            begin
                sum_v = {operand.a_vertical[31], operand.a_vertical};
                sum_h = {operand.a_horizontal[31], operand.a_horizontal};
            end
        endcase
        sat_v = sat32(XY_W'(sum_v));
        sat_h = sat32(XY_W'(sum_h));

        prod = xy_t'(operand.polar_length) * xy_t'(GAIN_Q30);

        ent_next.polar           = (operand.command == CMD_POLAR);
        ent_next.x               = prod >>> 2;
        ent_next.z               = z_t'(operand.polar_angle) <<< 17;
        ent_next.comp.vertical   = sat_v.val;
        ent_next.comp.horizontal = sat_h.val;
        ent_next.comp.overflow   = sat_v.ovf | sat_h.ovf;
    end

    // Entry stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            ent_vld_reg <= operand.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ent_reg <= ent_next;
        end
    end

    vpr_rotate #(
        .STAGES (CORDIC_STAGES)
    ) u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .req_valid (ent_vld_reg),
        .req       (ent_reg),
        .rsp_valid (rot_valid),
        .rsp       (rot_comp)
    );

    vpr_vector #(
        .STAGES (CORDIC_STAGES)
    ) u_vector (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .req_valid (rot_valid),
        .req       (rot_comp),
        .rsp_valid (vec_valid),
        .rsp       (vec_res)
    );

    // Output register with skid entry: hold a stalled result, park the next one
    always_comb
    begin
        up_fire       = vec_valid && advance;
        out_load      = !out_vld_reg || result.ready;
        out_vld_next  = out_vld_reg;
        out_next      = out_reg;
        skid_vld_next = skid_vld_reg;
        if (out_load)
        begin
            out_vld_next  = skid_vld_reg || up_fire;
            out_next      = skid_vld_reg ? skid_reg : vec_res;
            skid_vld_next = 1'b0;
        end
        else if (up_fire)
        begin
            skid_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (!out_load && up_fire)
        begin
            skid_reg <= vec_res;
        end
    end

    assign result.valid          = out_vld_reg;
    assign result.out_vertical   = out_reg.vertical;
    assign result.out_horizontal = out_reg.horizontal;
    assign result.out_length     = out_reg.length;
    assign result.out_angle      = out_reg.angle;
    assign result.overflow       = out_reg.overflow;

endmodule

`default_nettype wire
